// File: rtl/plsm_pkg.sv
package plsm_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 3;

    // link state codes, also the encoding of the conn_state field
    typedef enum logic [2:0] {
        ST_WAIT       = 3'd0,
        ST_PAIRING    = 3'd1,
        ST_PAIRED     = 3'd2,
        ST_CONNECTING = 3'd3,
        ST_CONNECTED  = 3'd4
    } conn_state_t;

    // item sequencer
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_DIV  = 2'd1,
        SEQ_DONE = 2'd2
    } seq_state_t;

    // item kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // link event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_PAIR_DONE    = 3'd1;
    localparam logic [2:0] EV_PAIR_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_CONN_DONE    = 3'd3;
    localparam logic [2:0] EV_CONN_TIMEOUT = 3'd4;
    localparam logic [2:0] EV_LINK_LOST    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRING_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRED_HOLD        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTING_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PAIR_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PAIR_RETRY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK         = 3'd6;

    // configuration reset values
    localparam logic [TIME_W-1:0] RST_PAIRING_TIMEOUT    = 32'd10000000;
    localparam logic [TIME_W-1:0] RST_PAIRED_HOLD        = 32'd500000;
    localparam logic [TIME_W-1:0] RST_CONNECTING_TIMEOUT = 32'd3000000;
    localparam logic [TIME_W-1:0] RST_AUTO_PAIR_RETRY    = 32'd1500000;
    localparam logic [TIME_W-1:0] RST_SLOW_BLINK         = 32'd1000000;
    localparam logic [TIME_W-1:0] RST_FAST_BLINK         = 32'd500000;

    // one-shot link commands of one result
    typedef struct packed {
        logic start_pair;
        logic stop_pair;
        logic start_conn;
        logic stop_conn;
        logic clear_bond;
    } cmd_t;

    // divider response
    typedef struct packed {
        logic done;
        logic q_lsb;
    } div_rsp_t;

endpackage

// File: rtl/pairing_link_state_machine_core.sv
// sequence: an item whose led follows a blink pattern starts the divider on its accepting
//   edge and waits for its quotient lsb, any other item skips the divider; the result then
//   loads into the output register once that register is free or its transfer completes
// throughput: one item at a time, the next transfer is taken only after the result loads
// reset: state wait, deadlines zero, led off, no pending pair request, registers at
//   their documented defaults, output empty
module pairing_link_state_machine_core (
    input  logic        clk,
    input  logic        rst_n,

    // item input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] now_us,
    input  logic [2:0]  link_event,
    input  logic        has_bond,
    input  logic        is_connected,
    input  logic        pair_request,
    input  logic        unpair_request,

    // result output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  conn_state,
    output logic        led_level,
    output logic        report_allowed,
    output logic        start_pairing_cmd,
    output logic        stop_pairing_cmd,
    output logic        start_connect_cmd,
    output logic        stop_connect_cmd,
    output logic        clear_bond_cmd,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // the auto pair delay is not stored: writes to its index are dropped, and the wait entry
    // of a start item sets the auto pair deadline from the retry register instead
    // ------------------------------------------------------------------
    logic [31:0] pair_to_reg, hold_reg, conn_to_reg, retry_reg, slow_reg, fast_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_to_reg <= plsm_pkg::RST_PAIRING_TIMEOUT;
            hold_reg    <= plsm_pkg::RST_PAIRED_HOLD;
            conn_to_reg <= plsm_pkg::RST_CONNECTING_TIMEOUT;
            retry_reg   <= plsm_pkg::RST_AUTO_PAIR_RETRY;
            slow_reg    <= plsm_pkg::RST_SLOW_BLINK;
            fast_reg    <= plsm_pkg::RST_FAST_BLINK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                plsm_pkg::CFG_PAIRING_TIMEOUT:    pair_to_reg <= cfg_data;
                plsm_pkg::CFG_PAIRED_HOLD:        hold_reg    <= cfg_data;
                plsm_pkg::CFG_CONNECTING_TIMEOUT: conn_to_reg <= cfg_data;
                plsm_pkg::CFG_AUTO_PAIR_RETRY:    retry_reg   <= cfg_data;
                plsm_pkg::CFG_SLOW_BLINK:         slow_reg    <= cfg_data;
                plsm_pkg::CFG_FAST_BLINK:         fast_reg    <= cfg_data;
                default:                          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // link state
    // ------------------------------------------------------------------
    plsm_pkg::conn_state_t mode_reg, mode_next;
    plsm_pkg::seq_state_t  seq_reg, seq_next;
    logic [31:0]           phase_dl_reg, phase_dl_next;
    logic [31:0]           auto_dl_reg, auto_dl_next;
    logic                  led_reg, led_next;
    logic                  pend_reg, pend_next;
    plsm_pkg::cmd_t        cmd_reg, cmd_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    plsm_pkg::conn_state_t out_state_reg, out_state_next;
    logic                  out_led_reg, out_led_next;
    plsm_pkg::cmd_t        out_cmd_reg, out_cmd_next;

    // shared divider for the blink phase
    logic                  div_start;
    logic [31:0]           div_den;
    plsm_pkg::div_rsp_t    div_rsp;

    plsm_div #(
        .WIDTH(plsm_pkg::TIME_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(now_us),
        .divisor (div_den),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // transition decision for the item on the input
    // deadlines use the sign of the wrapped difference
    // ------------------------------------------------------------------
    logic                  accept;
    logic [31:0]           phase_diff, auto_diff;
    logic                  phase_hit, auto_hit;
    logic                  go;
    plsm_pkg::conn_state_t tgt;
    logic                  dec_pend;
    logic                  dec_clear;
    logic                  blink_en;
    logic [31:0]           half;

    assign accept     = in_valid && !in_stall;
    assign phase_diff = now_us - phase_dl_reg;
    assign auto_diff  = now_us - auto_dl_reg;
    assign phase_hit  = ~phase_diff[31];
    assign auto_hit   = (auto_dl_reg != '0) && ~auto_diff[31];

    always_comb
    begin
        go        = 1'b0;
        tgt       = mode_reg;
        dec_clear = 1'b0;
        dec_pend  = pend_reg | pair_request;
        blink_en  = 1'b0;

        if (func == plsm_pkg::FUNC_START)
        begin
            dec_pend = 1'b0;
            go       = 1'b1;
            tgt      = plsm_pkg::ST_WAIT;
        end
        else if (unpair_request)
        begin
            dec_pend  = 1'b0;
            dec_clear = 1'b1;
            go        = 1'b1;
            tgt       = plsm_pkg::ST_WAIT;
        end
        else
        begin
            unique case (mode_reg)
                plsm_pkg::ST_WAIT:
                begin
                    priority if (dec_pend)
                    begin
                        dec_pend = 1'b0;
                        go       = 1'b1;
                        tgt      = plsm_pkg::ST_PAIRING;
                    end
                    else if (has_bond)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_CONNECTING;
                    end
                    else if (auto_hit)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_PAIRING;
                    end
                end
                plsm_pkg::ST_PAIRING:
                begin
                    priority if (link_event == plsm_pkg::EV_PAIR_DONE)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_PAIRED;
                    end
                    else if (link_event == plsm_pkg::EV_PAIR_TIMEOUT || phase_hit)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_WAIT;
                    end
                end
                plsm_pkg::ST_PAIRED:
                begin
                    if (phase_hit)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_CONNECTING;
                    end
                end
                plsm_pkg::ST_CONNECTING:
                begin
                    priority if (link_event == plsm_pkg::EV_CONN_DONE)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_CONNECTED;
                    end
                    else if (link_event == plsm_pkg::EV_CONN_TIMEOUT || phase_hit)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_WAIT;
                    end
                end
                plsm_pkg::ST_CONNECTED:
                begin
                    if (link_event == plsm_pkg::EV_LINK_LOST || !is_connected)
                    begin
                        go  = 1'b1;
                        tgt = plsm_pkg::ST_CONNECTING;
                    end
                end
                default:
                begin
                    // undefined mode code recovers into wait
                    go  = 1'b1;
                    tgt = plsm_pkg::ST_WAIT;
                end
            endcase

            // blink pattern follows the state after the transition
            blink_en = (tgt == plsm_pkg::ST_WAIT) || (tgt == plsm_pkg::ST_PAIRING)
                    || (tgt == plsm_pkg::ST_CONNECTING);
        end

        // slow blink in wait, fast blink otherwise; a zero half period counts as one
        half = (tgt == plsm_pkg::ST_WAIT) ? slow_reg : fast_reg;
        if (half == '0)
        begin
            half = 32'd1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: decide on the accepting edge, run the divider when the led
    // blinks, then move the result into the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        seq_next       = seq_reg;
        mode_next      = mode_reg;
        phase_dl_next  = phase_dl_reg;
        auto_dl_next   = auto_dl_reg;
        led_next       = led_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_state_next = out_state_reg;
        out_led_next   = out_led_reg;
        out_cmd_next   = out_cmd_reg;
        div_start      = 1'b0;
        div_den        = half;

        unique case (seq_reg)
            plsm_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    pend_next           = dec_pend;
                    cmd_next            = '0;
                    cmd_next.clear_bond = dec_clear;
                    if (go)
                    begin
                        mode_next = tgt;
                        led_next  = 1'b1;
                        unique case (tgt)
                            plsm_pkg::ST_WAIT:
                            begin
                                cmd_next.stop_pair = 1'b1;
                                cmd_next.stop_conn = 1'b1;
                                phase_dl_next      = '0;
                                auto_dl_next       = has_bond ? '0 : now_us + retry_reg;
                            end
                            plsm_pkg::ST_PAIRING:
                            begin
                                cmd_next.start_pair = 1'b1;
                                phase_dl_next       = now_us + pair_to_reg;
                            end
                            plsm_pkg::ST_PAIRED:
                            begin
                                cmd_next.stop_pair = 1'b1;
                                phase_dl_next      = now_us + hold_reg;
                            end
                            plsm_pkg::ST_CONNECTING:
                            begin
                                cmd_next.start_conn = 1'b1;
                                phase_dl_next       = now_us + conn_to_reg;
                            end
                            default:
                            begin
                                phase_dl_next = '0;
                            end
                        endcase
                    end
                    if (blink_en)
                    begin
                        div_start = 1'b1;
                        seq_next  = plsm_pkg::SEQ_DIV;
                    end
                    else
                    begin
                        seq_next = plsm_pkg::SEQ_DONE;
                    end
                end
            end
            plsm_pkg::SEQ_DIV:
            begin
                if (div_rsp.done)
                begin
                    // led on while the quotient is even
                    led_next = ~div_rsp.q_lsb;
                    seq_next = plsm_pkg::SEQ_DONE;
                end
            end
            plsm_pkg::SEQ_DONE:
            begin
                // output register is free or its transfer completes now
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = mode_reg;
                    out_led_next   = led_reg;
                    out_cmd_next   = cmd_reg;
                    seq_next       = plsm_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = plsm_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= plsm_pkg::SEQ_IDLE;
            mode_reg      <= plsm_pkg::ST_WAIT;
            phase_dl_reg  <= '0;
            auto_dl_reg   <= '0;
            led_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            mode_reg      <= mode_next;
            phase_dl_reg  <= phase_dl_next;
            auto_dl_reg   <= auto_dl_next;
            led_reg       <= led_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_state_reg <= out_state_next;
        out_led_reg   <= out_led_next;
        out_cmd_reg   <= out_cmd_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign in_stall          = (seq_reg != plsm_pkg::SEQ_IDLE);
    assign out_valid         = out_valid_reg;
    assign conn_state        = out_state_reg;
    assign led_level         = out_led_reg;
    assign report_allowed    = (out_state_reg == plsm_pkg::ST_CONNECTED);
    assign start_pairing_cmd = out_cmd_reg.start_pair;
    assign stop_pairing_cmd  = out_cmd_reg.stop_pair;
    assign start_connect_cmd = out_cmd_reg.start_conn;
    assign stop_connect_cmd  = out_cmd_reg.stop_conn;
    assign clear_bond_cmd    = out_cmd_reg.clear_bond;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (seq_reg == plsm_pkg::SEQ_DIV))
        else $error("divider finished outside the divide phase");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (seq_reg == plsm_pkg::SEQ_DIV || seq_reg == plsm_pkg::SEQ_DONE))
        else $error("accepted transfer did not start processing");

    a_start_pair_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cmd_reg.start_pair) |-> (out_state_reg == plsm_pkg::ST_PAIRING))
        else $error("start pairing command without pairing state");

    a_stop_conn_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cmd_reg.stop_conn) |-> (out_state_reg == plsm_pkg::ST_WAIT))
        else $error("stop connect command outside wait");

    a_deadline_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == plsm_pkg::ST_WAIT) |-> (phase_dl_reg == '0))
        else $error("phase deadline armed in wait");

endmodule

// File: rtl/plsm_div.sv
// restoring divider, one quotient bit per cycle, reports the quotient lsb
module plsm_div #(
    parameter int WIDTH = plsm_pkg::TIME_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [WIDTH-1:0]    dividend,
    input  logic [WIDTH-1:0]    divisor,
    output plsm_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             q_reg, q_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = ~diff[WIDTH];

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.q_lsb = q_reg;

endmodule
